@@ hw/rtl/fmc_pkg.sv @@
// ----------------------------------------------------------------------------
// fmc_pkg: shared types and constants for the framed message checker
// Register reset values, verdict codes, config and result structures.
// ----------------------------------------------------------------------------
package fmc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [1:0] CFG_TAIL_FIRST    = 2'd2;
    localparam logic [1:0] CFG_TAIL_SECOND   = 2'd3;

    // Register reset values
    localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [7:0] HEADER_SECOND_RST = 8'h55;
    localparam logic [7:0] TAIL_FIRST_RST    = 8'h0D;
    localparam logic [7:0] TAIL_SECOND_RST   = 8'h0A;

    // Frame geometry
    localparam int         POS_W          = 9;
    localparam logic [8:0] POS_MAX        = 9'd511;
    localparam logic [9:0] FRAME_OVERHEAD = 10'd8;

    // Verdict codes
    localparam logic [2:0] VERDICT_OK       = 3'd0;
    localparam logic [2:0] VERDICT_HEADER   = 3'd1;
    localparam logic [2:0] VERDICT_LENGTH   = 3'd2;
    localparam logic [2:0] VERDICT_CHECKSUM = 3'd3;
    localparam logic [2:0] VERDICT_TAIL     = 3'd4;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Output data width: 67 bits of fields padded to whole bytes
    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] tail_first;
        logic [7:0] tail_second;
    } cfg_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  msg_type;
        logic [7:0]  frame_length;
        logic [2:0]  verdict;
        logic [15:0] received_sum;
        logic [15:0] computed_sum;
    } result_t;

endpackage

@@ hw/rtl/framed_message_checker.sv @@
// ----------------------------------------------------------------------------
// framed_message_checker: byte-stream frame deframer with additive checksum
// Checks header, size, checksum and tail of each received buffer and passes
// payload bytes on with their index.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one received byte per transaction in s_tdata, with
//   s_tlast high on the last byte of the buffer.
//   Master channel m_*: m_tuser = 0 is a payload byte result, m_tuser = 1 the
//   verdict for the buffer that just ended. Header, type, length, checksum
//   and tail bytes produce no result; the last byte produces only the
//   verdict, even when it is a payload byte.
//   Configuration: cfg_we/cfg_index/cfg_data write the expected header and
//   tail bytes; write only while the block is idle.
// Timing:
//   A byte accepted is registered in the input register, processed by the core
//   and its result is registered in the result register that drives m_tvalid.
//   One byte per cycle is sustained while m_tready stays high; the frame state
//   update in the core is the feedback loop that sets this.
// Reset: clears the valid flags of both stage registers and the frame state;
//   configuration returns to 0xAA 0x55 header and 0x0D 0x0A tail.
// Stall: with m_tready low, the result is held and one more byte waits in the
//   input register, after which s_tready drops.
// ----------------------------------------------------------------------------
module framed_message_checker
    import fmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    // Input byte stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic                  s_tlast,   // end_of_buffer
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                             // [23:16] msg_type, [31:24] frame_length,
                                             // [34:32] verdict, [50:35] received_sum,
                                             // [66:51] computed_sum, [71:67] zero
    output logic                  m_tuser    // item_kind
);

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       advance;
    logic       has_result;
    result_t    result;

    fmc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Core step when a byte is held and the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    fmc_frame_core u_frame_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .step          (advance),
        .rx_byte       (in_byte_reg),
        .end_of_buffer (in_last_reg),
        .has_result    (has_result),
        .result        (result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= has_result;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.item_kind;
    assign m_tdata  = {5'd0,
                       out_reg.computed_sum,
                       out_reg.received_sum,
                       out_reg.verdict,
                       out_reg.frame_length,
                       out_reg.msg_type,
                       out_reg.payload_index,
                       out_reg.payload_byte};

endmodule

@@ hw/rtl/fmc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// fmc_cfg_regs: configuration register file
// Holds expected header and tail bytes, written through a plain write port.
// ----------------------------------------------------------------------------
module fmc_cfg_regs
    import fmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER_FIRST:  cfg_next.header_first  = cfg_data;
                CFG_HEADER_SECOND: cfg_next.header_second = cfg_data;
                CFG_TAIL_FIRST:    cfg_next.tail_first    = cfg_data;
                CFG_TAIL_SECOND:   cfg_next.tail_second   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= HEADER_FIRST_RST;
            cfg_reg.header_second <= HEADER_SECOND_RST;
            cfg_reg.tail_first    <= TAIL_FIRST_RST;
            cfg_reg.tail_second   <= TAIL_SECOND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/fmc_frame_core.sv @@
// ----------------------------------------------------------------------------
// fmc_frame_core: per-byte frame tracking and verdict logic
// Holds the frame state, classifies each byte by position and builds the
// result (payload pass-through or end-of-buffer verdict) in one pass.
// ----------------------------------------------------------------------------
module fmc_frame_core
    import fmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step,        // process the byte below this cycle
    input  logic [7:0] rx_byte,
    input  logic       end_of_buffer,
    output logic       has_result,
    output result_t    result
);

    logic [POS_W-1:0] pos_reg,         pos_next;
    logic [7:0]       type_reg,        type_next;
    logic [7:0]       length_reg,      length_next;
    logic [15:0]      sum_running_reg, sum_running_next;
    logic [15:0]      sum_carried_reg, sum_carried_next;
    logic             header_bad_reg,  header_bad_next;
    logic             tail_bad_reg,    tail_bad_next;

    logic [POS_W-1:0] off;
    logic [POS_W-1:0] len_ext;
    logic             is_payload;
    logic [9:0]       count;
    logic [9:0]       expected_count;
    logic [2:0]       verdict;

    assign off     = pos_reg - POS_W'(4);
    assign len_ext = {1'b0, length_reg};

    // Classify the byte and update the frame state
    always_comb
    begin
        type_next        = type_reg;
        length_next      = length_reg;
        sum_running_next = sum_running_reg;
        sum_carried_next = sum_carried_reg;
        header_bad_next  = header_bad_reg;
        tail_bad_next    = tail_bad_reg;
        is_payload       = 1'b0;

        case (pos_reg)
            9'd0:
            begin
                if (rx_byte != cfg.header_first)
                    header_bad_next = 1'b1;
            end
            9'd1:
            begin
                if (rx_byte != cfg.header_second)
                    header_bad_next = 1'b1;
            end
            9'd2:
            begin
                type_next        = rx_byte;
                sum_running_next = sum_running_reg + {8'd0, rx_byte};
            end
            9'd3:
            begin
                length_next      = rx_byte;
                sum_running_next = sum_running_reg + {8'd0, rx_byte};
            end
            default:
            begin
                if (off < len_ext)
                begin
                    sum_running_next = sum_running_reg + {8'd0, rx_byte};
                    is_payload       = 1'b1;
                end
                else if (off == len_ext || off == len_ext + 9'd1)
                begin
                    sum_carried_next = {sum_carried_reg[7:0], rx_byte};
                end
                else if (off == len_ext + 9'd2)
                begin
                    if (rx_byte != cfg.tail_first)
                        tail_bad_next = 1'b1;
                end
                else if (off == len_ext + 9'd3)
                begin
                    if (rx_byte != cfg.tail_second)
                        tail_bad_next = 1'b1;
                end
            end
        endcase
    end

    // Verdict on the updated state, in check order
    assign count          = {1'b0, pos_reg} + 10'd1;
    assign expected_count = {2'b00, length_next} + FRAME_OVERHEAD;

    always_comb
    begin
        if (header_bad_next || pos_reg == '0)
            verdict = VERDICT_HEADER;
        else if (count != expected_count)
            verdict = VERDICT_LENGTH;
        else if (sum_carried_next != sum_running_next)
            verdict = VERDICT_CHECKSUM;
        else if (tail_bad_next)
            verdict = VERDICT_TAIL;
        else
            verdict = VERDICT_OK;
    end

    // Result build
    always_comb
    begin
        result.msg_type     = type_next;
        result.frame_length = length_next;
        if (end_of_buffer)
        begin
            has_result            = 1'b1;
            result.item_kind      = KIND_VERDICT;
            result.payload_byte   = 8'd0;
            result.payload_index  = 8'd0;
            result.verdict        = verdict;
            result.received_sum   = sum_carried_next;
            result.computed_sum   = sum_running_next;
        end
        else
        begin
            has_result            = is_payload;
            result.item_kind      = KIND_PAYLOAD;
            result.payload_byte   = rx_byte;
            result.payload_index  = off[7:0];
            result.verdict        = VERDICT_OK;
            result.received_sum   = 16'd0;
            result.computed_sum   = 16'd0;
        end
    end

    // Byte counter saturates; a verdict returns the frame to its start
    assign pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            type_reg        <= '0;
            length_reg      <= '0;
            sum_running_reg <= '0;
            sum_carried_reg <= '0;
            header_bad_reg  <= 1'b0;
            tail_bad_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (end_of_buffer)
            begin
                pos_reg         <= '0;
                type_reg        <= '0;
                length_reg      <= '0;
                sum_running_reg <= '0;
                sum_carried_reg <= '0;
                header_bad_reg  <= 1'b0;
                tail_bad_reg    <= 1'b0;
            end
            else
            begin
                pos_reg         <= pos_next;
                type_reg        <= type_next;
                length_reg      <= length_next;
                sum_running_reg <= sum_running_next;
                sum_carried_reg <= sum_carried_next;
                header_bad_reg  <= header_bad_next;
                tail_bad_reg    <= tail_bad_next;
            end
        end
    end

endmodule
